// ===== hdl/tiaq_pkg.sv =====
// Shared types and defaults for the task ID allocator and round-robin queue.
package tiaq_pkg;

  // Default sizes
  localparam int IdCountDef    = 256;
  localparam int QueueSlotsDef = 64;

  // Command codes carried by the opcode field
  typedef enum logic [1:0] {
    OP_SPAWN = 2'd0,
    OP_ENQ   = 2'd1,
    OP_NEXT  = 2'd2,
    OP_KILL  = 2'd3
  } op_e;

  // Source of the result ID
  typedef enum logic [1:0] {
    RES_ZERO   = 2'd0,
    RES_FRESH  = 2'd1,
    RES_CHK_ID = 2'd2,
    RES_SLOT   = 2'd3
  } res_sel_e;

  // Controller to datapath
  typedef struct packed {
    logic     clear;        // write zero at the slot pointer and advance
    logic     load;         // capture the command word, set up the scan
    logic     fresh_spawn;  // hand out the fresh counter value
    logic     issue;        // issue one table read and advance the pointer
    logic     slot_wr_id;   // write the captured ID into the checked slot
    logic     slot_wr_zero; // empty the checked slot
    logic     alive_set;    // mark the checked ID alive
    logic     alive_clr;    // mark the captured ID dead
    logic     pos_upd;      // scan position takes the checked slot
    logic     finish;       // present the result word
    logic     ok;           // accepted flag of the result word
    res_sel_e res_sel;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_last;  // clearing pass is at the final slot
    logic fresh_avail; // fresh counter below the ID limit
    logic chk_vld;     // read data of one entry is present
    logic chk_last;    // that entry is the last of the scan
    logic slot_zero;   // checked slot is empty
    logic slot_match;  // checked slot holds the captured ID
    logic alive_bit;   // alive bit of the checked ID
  } dp_sts_t;

endpackage

// ===== hdl/task_id_allocator_round_robin_queue.sv =====
// Top level of the task ID allocator with round-robin slot queue.
//
// Command channel: a word (opcode_i, task_id_i) is taken at a rising edge
// where start is high and busy is low. Opcodes: spawn, enqueue, next, kill.
// Result channel: done_o marks result_id_o and accepted_o for exactly one
// cycle; the receiver cannot stall, so every result is taken when shown.
// One word is worked on at a time; busy is low again in the done cycle, so
// the next word can be taken at the edge that takes the result.
// Work done from the accepting edge to the done cycle:
//   spawn from the fresh counter: no scan, result registered at that edge
//   spawn after the counter is used up: scan of the alive bits of IDs 1 up
//   to ID_COUNT - 1; enqueue, next and kill: scan of up to QUEUE_SLOTS slots
// The scans walk one table entry per cycle through the single read port of
// the slot table or of the alive bit memory.
// Reset: the fresh counter returns to 1 and the scan position to slot 0;
// a clearing pass then empties the slot table, one slot per cycle, during
// which busy is high and no word is taken.
module task_id_allocator_round_robin_queue #(
  parameter int ID_COUNT    = tiaq_pkg::IdCountDef,
  parameter int QUEUE_SLOTS = tiaq_pkg::QueueSlotsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] opcode_i,
  input  logic [7:0] task_id_i,
  output logic       done_o,
  output logic [7:0] result_id_o,
  output logic       accepted_o
);
  import tiaq_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  op_e     op;

  assign op = op_e'(opcode_i);

  tiaq_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .opcode_i (op),
    .sts_i    (sts),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  tiaq_dp #(
    .IdCount    (ID_COUNT),
    .QueueSlots (QUEUE_SLOTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .opcode_i    (op),
    .task_id_i   (task_id_i),
    .sts_o       (sts),
    .done_o      (done_o),
    .result_id_o (result_id_o),
    .accepted_o  (accepted_o)
  );

endmodule

// ===== hdl/tiaq_dp.sv =====
// Datapath: fresh counter, alive bit memory, slot table memory and scan pointers.
module tiaq_dp #(
  parameter int IdCount    = 256,
  parameter int QueueSlots = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tiaq_pkg::dp_cmd_t cmd_i,
  input  tiaq_pkg::op_e     opcode_i,
  input  logic [7:0]        task_id_i,
  output tiaq_pkg::dp_sts_t sts_o,
  output logic              done_o,
  output logic [7:0]        result_id_o,
  output logic              accepted_o
);
  import tiaq_pkg::*;

  localparam int IdW     = $clog2(IdCount);
  localparam int FreshW  = $clog2(IdCount + 1);
  localparam int SlotW   = $clog2(QueueSlots);
  localparam int ScanMax = (QueueSlots > IdCount - 1) ? QueueSlots : IdCount - 1;
  localparam int LeftW   = $clog2(ScanMax + 1);

  // Control registers
  logic [FreshW-1:0] fresh_q, fresh_d;
  logic [SlotW-1:0]  pos_q, pos_d;
  logic [SlotW-1:0]  slot_ptr_q, slot_ptr_d;
  logic [IdW-1:0]    id_ptr_q, id_ptr_d;
  logic [LeftW-1:0]  left_q, left_d;
  op_e               op_q, op_d;
  logic              chk_vld_q, chk_vld_d;
  logic              done_q;

  // Payload registers
  logic [7:0]        id_q;
  logic              chk_last_q;
  logic [SlotW-1:0]  chk_slot_q;
  logic [IdW-1:0]    chk_id_q;
  logic [7:0]        slot_rd_q;
  logic              alive_rd_q;
  logic [7:0]        result_q;
  logic              acc_q;

  // Memories
  logic [7:0] slot_mem [QueueSlots];
  logic       alive_mem [IdCount];

  logic             do_issue;
  logic [SlotW-1:0] slot_ptr_inc;
  logic [SlotW-1:0] pos_inc;
  logic             kill_in_range;
  logic             slot_we;
  logic [SlotW-1:0] slot_wa;
  logic [7:0]       slot_wd;
  logic             alive_we;
  logic [IdW-1:0]   alive_wa;
  logic             alive_wd;

  assign do_issue      = cmd_i.issue && (left_q != '0);
  assign slot_ptr_inc  = (slot_ptr_q == SlotW'(QueueSlots - 1)) ? '0 : slot_ptr_q + 1'b1;
  assign pos_inc       = (pos_q == SlotW'(QueueSlots - 1)) ? '0 : pos_q + 1'b1;
  assign kill_in_range = (32'(id_q) < IdCount);

  // Next state of the scan control
  always_comb begin
    fresh_d    = fresh_q;
    pos_d      = pos_q;
    slot_ptr_d = slot_ptr_q;
    id_ptr_d   = id_ptr_q;
    left_d     = left_q;
    op_d       = op_q;
    chk_vld_d  = do_issue;
    if (cmd_i.load) begin
      op_d       = opcode_i;
      left_d     = (opcode_i == OP_SPAWN) ? LeftW'(IdCount - 1) : LeftW'(QueueSlots);
      id_ptr_d   = IdW'(1);
      slot_ptr_d = (opcode_i == OP_NEXT) ? pos_inc : '0;
      chk_vld_d  = 1'b0;
    end else if (do_issue) begin
      left_d = left_q - 1'b1;
      if (op_q == OP_SPAWN) begin
        id_ptr_d = id_ptr_q + 1'b1;
      end else begin
        slot_ptr_d = slot_ptr_inc;
      end
    end
    if (cmd_i.clear) begin
      slot_ptr_d = slot_ptr_inc;
    end
    if (cmd_i.fresh_spawn) begin
      fresh_d = fresh_q + 1'b1;
    end
    if (cmd_i.pos_upd) begin
      pos_d = chk_slot_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fresh_q    <= FreshW'(1);
      pos_q      <= '0;
      slot_ptr_q <= '0;
      id_ptr_q   <= '0;
      left_q     <= '0;
      op_q       <= OP_SPAWN;
      chk_vld_q  <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      fresh_q    <= fresh_d;
      pos_q      <= pos_d;
      slot_ptr_q <= slot_ptr_d;
      id_ptr_q   <= id_ptr_d;
      left_q     <= left_d;
      op_q       <= op_d;
      chk_vld_q  <= chk_vld_d;
      done_q     <= cmd_i.finish;
    end
  end

  // Command word capture, read tags and result word
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      id_q <= task_id_i;
    end
    if (do_issue) begin
      chk_last_q <= (left_q == LeftW'(1));
      chk_slot_q <= slot_ptr_q;
      chk_id_q   <= id_ptr_q;
    end
    if (cmd_i.finish) begin
      acc_q <= cmd_i.ok;
      case (cmd_i.res_sel)
        RES_FRESH:  result_q <= 8'(fresh_q);
        RES_CHK_ID: result_q <= 8'(chk_id_q);
        RES_SLOT:   result_q <= slot_rd_q;
        default:    result_q <= '0;
      endcase
    end
  end

  // Write port selection
  assign slot_we  = cmd_i.clear | cmd_i.slot_wr_id | cmd_i.slot_wr_zero;
  assign slot_wa  = cmd_i.clear ? slot_ptr_q : chk_slot_q;
  assign slot_wd  = cmd_i.slot_wr_id ? id_q : '0;
  assign alive_we = cmd_i.fresh_spawn | cmd_i.alive_set | (cmd_i.alive_clr & kill_in_range);
  assign alive_wa = cmd_i.fresh_spawn ? IdW'(fresh_q) :
                    cmd_i.alive_set   ? chk_id_q : IdW'(id_q);
  assign alive_wd = cmd_i.fresh_spawn | cmd_i.alive_set;

  // Slot table: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_mem[slot_wa] <= slot_wd;
    end
    if (do_issue) begin
      slot_rd_q <= slot_mem[slot_ptr_q];
    end
  end

  // Alive bits: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (alive_we) begin
      alive_mem[alive_wa] <= alive_wd;
    end
    if (do_issue) begin
      alive_rd_q <= alive_mem[id_ptr_q];
    end
  end

  // Status back to the controller
  assign sts_o.clear_last  = (slot_ptr_q == SlotW'(QueueSlots - 1));
  assign sts_o.fresh_avail = (fresh_q < FreshW'(IdCount));
  assign sts_o.chk_vld     = chk_vld_q;
  assign sts_o.chk_last    = chk_last_q;
  assign sts_o.slot_zero   = (slot_rd_q == '0);
  assign sts_o.slot_match  = (slot_rd_q == id_q);
  assign sts_o.alive_bit   = alive_rd_q;

  assign done_o      = done_q;
  assign result_id_o = result_q;
  assign accepted_o  = acc_q;

endmodule

// ===== hdl/tiaq_ctrl.sv =====
// Controller: sequences the clearing pass and the table scans of each command.
module tiaq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  tiaq_pkg::op_e     opcode_i,
  input  tiaq_pkg::dp_sts_t sts_i,
  output tiaq_pkg::dp_cmd_t cmd_o,
  output logic              busy_o
);
  import tiaq_pkg::*;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_SPAWN = 6'b000100,
    S_ENQ   = 6'b001000,
    S_NEXT  = 6'b010000,
    S_KILL  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          unique case (opcode_i)
            OP_SPAWN: begin
              if (sts_i.fresh_avail) begin
                cmd_o.fresh_spawn = 1'b1;
                cmd_o.finish      = 1'b1;
                cmd_o.ok          = 1'b1;
                cmd_o.res_sel     = RES_FRESH;
              end else begin
                state_d = S_SPAWN;
              end
            end
            OP_ENQ:  state_d = S_ENQ;
            OP_NEXT: state_d = S_NEXT;
            default: state_d = S_KILL;
          endcase
        end
      end
      S_SPAWN: begin
        // lowest dead ID from 1 upward
        cmd_o.issue = 1'b1;
        if (sts_i.chk_vld) begin
          if (!sts_i.alive_bit) begin
            cmd_o.alive_set = 1'b1;
            cmd_o.finish    = 1'b1;
            cmd_o.ok        = 1'b1;
            cmd_o.res_sel   = RES_CHK_ID;
            state_d         = S_IDLE;
          end else if (sts_i.chk_last) begin
            cmd_o.finish = 1'b1;
            state_d      = S_IDLE;
          end
        end
      end
      S_ENQ: begin
        // first empty slot takes the ID
        cmd_o.issue = 1'b1;
        if (sts_i.chk_vld) begin
          if (sts_i.slot_zero) begin
            cmd_o.slot_wr_id = 1'b1;
            cmd_o.finish     = 1'b1;
            cmd_o.ok         = 1'b1;
            state_d          = S_IDLE;
          end else if (sts_i.chk_last) begin
            cmd_o.finish = 1'b1;
            state_d      = S_IDLE;
          end
        end
      end
      S_NEXT: begin
        // slots after the position, the start slot read last
        cmd_o.issue = 1'b1;
        if (sts_i.chk_vld && (sts_i.chk_last || !sts_i.slot_zero)) begin
          cmd_o.pos_upd = 1'b1;
          cmd_o.finish  = 1'b1;
          cmd_o.res_sel = RES_SLOT;
          state_d       = S_IDLE;
        end
      end
      S_KILL: begin
        // empty every slot holding the ID, then drop its alive bit
        cmd_o.issue = 1'b1;
        if (sts_i.chk_vld && sts_i.slot_match) begin
          cmd_o.slot_wr_zero = 1'b1;
        end
        if (sts_i.chk_vld && sts_i.chk_last) begin
          cmd_o.alive_clr = 1'b1;
          cmd_o.finish    = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

endmodule
